// ===== src/tli_pkg.sv =====
// tli_pkg: widths, transaction types and stage carry types for the two-line
// intersection block. no dependencies.
package tli_pkg;

    localparam int COORD_BITS = 16;
    localparam int RES_W      = 32;
    localparam int DX_W       = COORD_BITS + 1;
    localparam int P_W        = 2 * COORD_BITS;
    localparam int C_W        = 2 * COORD_BITS + 1;
    localparam int DP_W       = 2 * COORD_BITS + 2;
    localparam int DEN_W      = 2 * COORD_BITS + 3;
    localparam int NP_W       = 3 * COORD_BITS + 2;
    localparam int NS_W       = 3 * COORD_BITS + 3;
    localparam int YP_W       = DX_W + RES_W;
    localparam int YS_W       = YP_W + 1;
    localparam int NUM_W      = (NS_W > YS_W) ? NS_W : YS_W;
    localparam int CMP_W      = (NUM_W > DEN_W + RES_W) ? NUM_W : DEN_W + RES_W;
    localparam int QSTG       = RES_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] line_a_x1;
        logic signed [COORD_BITS-1:0] line_a_y1;
        logic signed [COORD_BITS-1:0] line_a_x2;
        logic signed [COORD_BITS-1:0] line_a_y2;
        logic signed [COORD_BITS-1:0] line_b_x1;
        logic signed [COORD_BITS-1:0] line_b_y1;
        logic signed [COORD_BITS-1:0] line_b_x2;
        logic signed [COORD_BITS-1:0] line_b_y2;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] cross_x;
        logic signed [RES_W-1:0] cross_y;
        logic                    found;
    } t_out;

    typedef struct packed {
        logic                    found;
        logic                    direct;
        logic signed [RES_W-1:0] x;
        logic signed [DX_W-1:0]  dx;
        logic signed [DX_W-1:0]  dy;
        logic signed [C_W-1:0]   c;
    } t_carry;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
        t_carry           carry;
    } t_div_in;

endpackage

// ===== src/tli_front.sv =====
// tli_front: four pipeline stages forming line deltas, line constants,
// the cross denominator and numerator. depends on tli_pkg.
module tli_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  tli_pkg::t_in     i_item,
    output logic             o_valid,
    output tli_pkg::t_div_in o_div
);
    import tli_pkg::*;

    typedef struct packed {
        logic signed [DX_W-1:0]       dxa;
        logic signed [DX_W-1:0]       dya;
        logic signed [DX_W-1:0]       dxb;
        logic signed [DX_W-1:0]       dyb;
        logic signed [P_W-1:0]        pa1;
        logic signed [P_W-1:0]        pa2;
        logic signed [P_W-1:0]        pb1;
        logic signed [P_W-1:0]        pb2;
        logic signed [COORD_BITS-1:0] ax1;
        logic signed [COORD_BITS-1:0] bx1;
    } t_s1;

    typedef struct packed {
        logic signed [DX_W-1:0]       dxa;
        logic signed [DX_W-1:0]       dya;
        logic signed [DX_W-1:0]       dxb;
        logic signed [DX_W-1:0]       dyb;
        logic signed [C_W-1:0]        ca;
        logic signed [C_W-1:0]        cb;
        logic signed [DP_W-1:0]       dd1;
        logic signed [DP_W-1:0]       dd2;
        logic signed [COORD_BITS-1:0] ax1;
        logic signed [COORD_BITS-1:0] bx1;
    } t_s2;

    typedef struct packed {
        logic signed [DEN_W-1:0] den;
        logic signed [NP_W-1:0]  na;
        logic signed [NP_W-1:0]  nb;
        t_carry                  carry;
    } t_s3;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_div_in r_s4, n_s4;
    logic [3:0] r_v;

    always_comb begin
        n_s1.dxa = DX_W'(i_item.line_a_x2) - DX_W'(i_item.line_a_x1);
        n_s1.dya = DX_W'(i_item.line_a_y2) - DX_W'(i_item.line_a_y1);
        n_s1.dxb = DX_W'(i_item.line_b_x2) - DX_W'(i_item.line_b_x1);
        n_s1.dyb = DX_W'(i_item.line_b_y2) - DX_W'(i_item.line_b_y1);
        n_s1.pa1 = i_item.line_a_x2 * i_item.line_a_y1;
        n_s1.pa2 = i_item.line_a_x1 * i_item.line_a_y2;
        n_s1.pb1 = i_item.line_b_x2 * i_item.line_b_y1;
        n_s1.pb2 = i_item.line_b_x1 * i_item.line_b_y2;
        n_s1.ax1 = i_item.line_a_x1;
        n_s1.bx1 = i_item.line_b_x1;
    end

    always_comb begin
        n_s2.dxa = r_s1.dxa;
        n_s2.dya = r_s1.dya;
        n_s2.dxb = r_s1.dxb;
        n_s2.dyb = r_s1.dyb;
        n_s2.ca  = C_W'(r_s1.pa1) - C_W'(r_s1.pa2);
        n_s2.cb  = C_W'(r_s1.pb1) - C_W'(r_s1.pb2);
        n_s2.dd1 = r_s1.dya * r_s1.dxb;
        n_s2.dd2 = r_s1.dyb * r_s1.dxa;
        n_s2.ax1 = r_s1.ax1;
        n_s2.bx1 = r_s1.bx1;
    end

    always_comb begin
        logic va;
        logic vb;
        va = (r_s2.dxa == '0);
        vb = (r_s2.dxb == '0);
        n_s3.den = DEN_W'(r_s2.dd1) - DEN_W'(r_s2.dd2);
        n_s3.na  = r_s2.cb * r_s2.dxa;
        n_s3.nb  = r_s2.ca * r_s2.dxb;
        n_s3.carry.found  = !(va && vb) && (va || vb || (n_s3.den != '0));
        n_s3.carry.direct = va ^ vb;
        n_s3.carry.x      = va ? RES_W'(r_s2.ax1) : RES_W'(r_s2.bx1);
        if (va) begin
            n_s3.carry.dx = r_s2.dxb;
            n_s3.carry.dy = r_s2.dyb;
            n_s3.carry.c  = r_s2.cb;
        end else begin
            n_s3.carry.dx = r_s2.dxa;
            n_s3.carry.dy = r_s2.dya;
            n_s3.carry.c  = r_s2.ca;
        end
    end

    always_comb begin
        logic signed [NS_W-1:0] num;
        logic [NS_W-1:0]        num_mag;
        logic [DEN_W-1:0]       den_mag;
        num     = NS_W'(r_s3.na) - NS_W'(r_s3.nb);
        num_mag = num[NS_W-1] ? NS_W'(-num) : NS_W'(num);
        den_mag = r_s3.den[DEN_W-1] ? DEN_W'(-r_s3.den) : DEN_W'(r_s3.den);
        n_s4.num   = NUM_W'(num_mag);
        n_s4.den   = den_mag;
        n_s4.neg   = num[NS_W-1] ^ r_s3.den[DEN_W-1];
        n_s4.carry = r_s3.carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_valid = r_v[3];
    assign o_div   = r_s4;

endmodule

// ===== src/tli_div.sv =====
// tli_div: pipelined restoring divider, one quotient bit per stage, with
// signed saturation to 32 bits and a carried side payload. depends on tli_pkg.
module tli_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  tli_pkg::t_div_in               i_div,
    output logic                           o_valid,
    output logic signed [tli_pkg::RES_W-1:0] o_q,
    output tli_pkg::t_carry                o_carry
);
    import tli_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             ovf;
        logic [RES_W-1:0] q;
        t_carry           carry;
    } t_dstg;

    t_dstg r_stg [0:QSTG];
    t_dstg n_stg [0:QSTG];
    logic [QSTG:0] r_v;

    always_comb begin
        logic [CMP_W-1:0] sh;
        n_stg[0].rem   = i_div.num;
        n_stg[0].den   = i_div.den;
        n_stg[0].neg   = i_div.neg;
        n_stg[0].q     = '0;
        n_stg[0].carry = i_div.carry;
        n_stg[0].ovf   = CMP_W'(i_div.num) >= (CMP_W'(i_div.den) << RES_W);
        for (int j = 1; j <= QSTG; j++) begin
            n_stg[j] = r_stg[j-1];
            sh = CMP_W'(r_stg[j-1].den) << (QSTG - j);
            if (CMP_W'(r_stg[j-1].rem) >= sh) begin
                n_stg[j].rem          = r_stg[j-1].rem - NUM_W'(sh);
                n_stg[j].q[QSTG - j]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QSTG-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j <= QSTG; j++) begin
                r_stg[j] <= n_stg[j];
            end
        end
    end

    localparam logic [RES_W-1:0] MIN_MAG = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] MAX_POS = {1'b0, {(RES_W-1){1'b1}}};

    always_comb begin
        if (r_stg[QSTG].neg) begin
            if (r_stg[QSTG].ovf || (r_stg[QSTG].q > MIN_MAG)) begin
                o_q = MIN_MAG;
            end else begin
                o_q = (~r_stg[QSTG].q) + RES_W'(1);
            end
        end else begin
            if (r_stg[QSTG].ovf || r_stg[QSTG].q[RES_W-1]) begin
                o_q = MAX_POS;
            end else begin
                o_q = r_stg[QSTG].q;
            end
        end
    end

    assign o_valid = r_v[QSTG];
    assign o_carry = r_stg[QSTG].carry;

endmodule

// ===== src/tli_yprep.sv =====
// tli_yprep: picks x, multiplies by the y-line slope term and adds the line
// constant, forming the y dividend and divisor. depends on tli_pkg.
module tli_yprep (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [tli_pkg::RES_W-1:0] i_x,
    input  tli_pkg::t_carry                  i_carry,
    output logic                             o_valid,
    output tli_pkg::t_div_in                 o_div
);
    import tli_pkg::*;

    typedef struct packed {
        logic signed [YP_W-1:0] mul;
        t_carry                 carry;
    } t_sa;

    t_sa     r_sa, n_sa;
    t_div_in r_sb, n_sb;
    logic [1:0] r_v;

    always_comb begin
        logic signed [RES_W-1:0] xs;
        xs          = i_carry.direct ? i_carry.x : i_x;
        n_sa.carry  = i_carry;
        n_sa.carry.x = xs;
        n_sa.mul    = i_carry.dy * xs;
    end

    always_comb begin
        logic signed [YS_W-1:0] n;
        logic [YS_W-1:0]        n_mag;
        logic [DX_W-1:0]        d_mag;
        n       = YS_W'(r_sa.mul) + YS_W'(r_sa.carry.c);
        n_mag   = n[YS_W-1] ? YS_W'(-n) : YS_W'(n);
        d_mag   = r_sa.carry.dx[DX_W-1] ? DX_W'(-r_sa.carry.dx) : DX_W'(r_sa.carry.dx);
        n_sb.num   = NUM_W'(n_mag);
        n_sb.den   = DEN_W'(d_mag);
        n_sb.neg   = n[YS_W-1] ^ r_sa.carry.dx[DX_W-1];
        n_sb.carry = r_sa.carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
        end
    end

    assign o_valid = r_v[1];
    assign o_div   = r_sb;

endmodule

// ===== src/two_line_intersection.sv =====
// two_line_intersection: top level, chains front stages, x divider, y setup,
// y divider, output register and skid stage. depends on tli_pkg and submodules.
//
// input channel: i_valid / o_stall carry one pair of lines per transaction
// in i_item. output channel: o_valid / i_stall carry cross_x, cross_y and
// found in o_item; x and y are zero when found is low.
// a transaction is taken at a rising edge with valid high and stall low.
// throughput: one transaction per cycle while o_stall is low.
// path from input to the output register: four front stages,
// two 33-stage dividers, two y setup stages, output register.
// the two restoring dividers, one quotient bit per stage, set the depth.
// the pipeline advances as a whole while the skid stage is empty; when the
// receiver stalls, the output holds and one more result lands in the skid
// stage, after which o_stall rises until the skid drains.
// reset (synchronous, active low) empties every stage and both output
// registers; no transaction is lost or repeated under any stall pattern.
module two_line_intersection (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tli_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output tli_pkg::t_out o_item
);
    import tli_pkg::*;

    logic                    en;
    logic                    f_valid;
    t_div_in                 f_div;
    logic                    dx_valid;
    logic signed [RES_W-1:0] dx_q;
    t_carry                  dx_carry;
    logic                    yp_valid;
    t_div_in                 yp_div;
    logic                    dy_valid;
    logic signed [RES_W-1:0] dy_q;
    t_carry                  dy_carry;
    t_out                    p_d;
    logic                    r_ov, r_sv;
    t_out                    r_od, r_sd;

    assign en = !r_sv;

    tli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_div   (f_div)
    );

    tli_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_div   (f_div),
        .o_valid (dx_valid),
        .o_q     (dx_q),
        .o_carry (dx_carry)
    );

    tli_yprep u_yprep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dx_valid),
        .i_x     (dx_q),
        .i_carry (dx_carry),
        .o_valid (yp_valid),
        .o_div   (yp_div)
    );

    tli_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (yp_valid),
        .i_div   (yp_div),
        .o_valid (dy_valid),
        .o_q     (dy_q),
        .o_carry (dy_carry)
    );

    always_comb begin
        p_d.found   = dy_carry.found;
        p_d.cross_x = dy_carry.found ? dy_carry.x : '0;
        p_d.cross_y = dy_carry.found ? dy_q : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= dy_valid;
            end
        end else if (dy_valid && en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_od <= r_sv ? r_sd : p_d;
        end else if (dy_valid && en) begin
            r_sd <= p_d;
        end
    end

    assign o_stall = r_sv;
    assign o_valid = r_ov;
    assign o_item  = r_od;

endmodule

// ===== tb/two_line_intersection_tb.sv =====
// two_line_intersection_tb: self-checking testbench for the two-line intersection
// block, with a queue-fed driver, a monitor and an exact intersection predictor.
// depends on tli_pkg and two_line_intersection.
module two_line_intersection_tb;
    import tli_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 200;
    localparam int HOLD_LEN   = 300;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_item;
    logic o_valid;
    logic i_stall;
    t_out o_item;

    t_in  pending_lines[$];
    t_out expected_cross[$];
    int   mismatches;
    int   idle_cycles;
    bit   stim_done;
    bit   hold_request;
    bit   hold_taken;
    int   send_gap;
    int   recv_gap;
    int   hold_left;

    two_line_intersection uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // y on a non-vertical line at x, truncated toward zero
    function automatic longint line_y(longint dx, longint dy, longint c, longint x);
        return sat_word((dy * x + c) / dx);
    endfunction

    function automatic t_out predict_cross(t_in it);
        longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        longint dxa, dya, ca, dxb, dyb, cb, den, x, y;
        logic signed [127:0] num, q;
        t_out r;
        ax1 = it.line_a_x1; ay1 = it.line_a_y1; ax2 = it.line_a_x2; ay2 = it.line_a_y2;
        bx1 = it.line_b_x1; by1 = it.line_b_y1; bx2 = it.line_b_x2; by2 = it.line_b_y2;
        dxa = ax2 - ax1; dya = ay2 - ay1; ca = ax2 * ay1 - ax1 * ay2;
        dxb = bx2 - bx1; dyb = by2 - by1; cb = bx2 * by1 - bx1 * by2;
        x = 0; y = 0;
        r.found = 1'b1;
        if (dxa != 0 && dxb == 0) begin
            x = bx1;
            y = line_y(dxa, dya, ca, x);
        end else if (dxa == 0 && dxb != 0) begin
            x = ax1;
            y = line_y(dxb, dyb, cb, x);
        end else if (dxa == 0 && dxb == 0) begin
            r.found = 1'b0;
        end else begin
            den = dya * dxb - dyb * dxa;
            if (den != 0) begin
                num = 128'(cb) * 128'(dxa) - 128'(ca) * 128'(dxb);
                q = num / 128'(den);
                if (q > 128'sd2147483647) x = 64'sd2147483647;
                else if (q < -128'sd2147483648) x = -64'sd2147483648;
                else x = longint'(q);
                y = line_y(dxa, dya, ca, x);
            end else begin
                r.found = 1'b0;
            end
        end
        r.cross_x = x[31:0];
        r.cross_y = y[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff - 16'($urandom_range(0, 3));
            1: return 16'sh8000 + 16'($urandom_range(0, 3));
            2: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in rand_lines();
        t_in it;
        it.line_a_x1 = rand_coord(); it.line_a_y1 = rand_coord();
        it.line_a_x2 = rand_coord(); it.line_a_y2 = rand_coord();
        it.line_b_x1 = rand_coord(); it.line_b_y1 = rand_coord();
        it.line_b_x2 = rand_coord(); it.line_b_y2 = rand_coord();
        case ($urandom_range(0, 9))
            0: it.line_a_x2 = it.line_a_x1;
            1: it.line_b_x2 = it.line_b_x1;
            2: begin
                it.line_a_x2 = it.line_a_x1;
                it.line_b_x2 = it.line_b_x1;
            end
            3: begin
                // parallel lines: B is A shifted
                it.line_b_x1 = it.line_a_x1 + 16'sd3;
                it.line_b_x2 = it.line_a_x2 + 16'sd3;
                it.line_b_y1 = it.line_a_y1 - 16'sd7;
                it.line_b_y2 = it.line_a_y2 - 16'sd7;
            end
            4: begin
                it.line_a_x2 = it.line_a_x1; it.line_a_y2 = it.line_a_y1;
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_in mk(int ax1, int ay1, int ax2, int ay2,
                               int bx1, int by1, int bx2, int by2);
        t_in it;
        it.line_a_x1 = 16'(ax1); it.line_a_y1 = 16'(ay1);
        it.line_a_x2 = 16'(ax2); it.line_a_y2 = 16'(ay2);
        it.line_b_x1 = 16'(bx1); it.line_b_y1 = 16'(by1);
        it.line_b_x2 = 16'(bx2); it.line_b_y2 = 16'(by2);
        return it;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        pending_lines.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0));
        pending_lines.push_back(mk(5, 0, 5, 9, 0, 0, 3, 6));
        pending_lines.push_back(mk(0, 0, 3, 6, -7, 1, -7, 4));
        pending_lines.push_back(mk(2, 0, 2, 5, 2, 1, 2, 9));
        pending_lines.push_back(mk(2, 0, 2, 5, 4, 1, 4, 9));
        pending_lines.push_back(mk(0, 0, 2, 4, 1, 0, 3, 4));
        pending_lines.push_back(mk(0, 0, 2, 4, 1, 2, 3, 6));
        pending_lines.push_back(mk(3, 3, 3, 3, 0, 0, 1, 1));
        pending_lines.push_back(mk(0, 0, 1, 1, 3, 3, 3, 3));
        pending_lines.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        pending_lines.push_back(mk(-32768, 0, -32767, 32767, 32767, 0, 32766, 32767));
        pending_lines.push_back(mk(0, -32768, 1, 32767, 0, -32767, 1, 32767));
        pending_lines.push_back(mk(32767, 32767, -32768, -32768, 0, 32767, 1, -32768));
        pending_lines.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_lines.push_back(mk(-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767));
        pending_lines.push_back(mk(1, -32768, 2, 32767, -32768, 1, 32767, 2));
        for (int i = 0; i < 560; i++) pending_lines.push_back(rand_lines());
        // receiver hold while the sender keeps offering
        hold_request = 1'b1;
        for (int i = 0; i < 280; i++) pending_lines.push_back(rand_lines());
        wait (pending_lines.size() == 0);
        @(posedge i_clk);
        wait (expected_cross.size() == 0);
        repeat ($urandom_range(1, 20)) @(posedge i_clk);
        for (int i = 0; i < 300; i++) pending_lines.push_back(rand_lines());
        wait (pending_lines.size() == 0);
        @(posedge i_clk);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item <= '0;
            send_gap <= 0;
        end else if (i_valid && o_stall) begin
        end else begin
            if (i_valid) begin
                expected_cross.push_back(predict_cross(i_item));
                void'(pending_lines.pop_front());
            end
            if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_lines.size() > 0) begin
                i_valid <= 1'b1;
                i_item <= pending_lines[0];
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
            hold_taken <= 1'b0;
            mismatches <= 0;
            idle_cycles <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_cross.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %p", o_item);
                end else begin
                    if (o_item !== expected_cross[0]) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p, got %p", expected_cross[0], o_item);
                    end
                    void'(expected_cross.pop_front());
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (hold_request && !hold_taken && !stim_done) begin
                hold_taken <= 1'b1;
                hold_left <= HOLD_LEN;
                i_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (o_valid && !i_stall)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_cross.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_cross.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
